/* rtl/sati_pkg.sv */
package sati_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ANGLE_W     = 16;
  localparam int ENTRY_W     = 2 * ANGLE_W;
  localparam int DIV_STEPS   = ANGLE_W;
  localparam int DIV_W       = $clog2(DIV_STEPS);
  localparam int COUNT_W     = 5;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_MUL,
    S_DIV,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             load;
    logic             start;
    logic             scan_rd;
    logic [IDX_W-1:0] rd_addr;
    logic             check;
    logic             mul;
    logic             div_step;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic miss;
    logic same;
    logic out_free;
  } status_t;

endpackage

/* rtl/sati_ram.sv */
module sati_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/sati_ctrl.sv */
module sati_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_func,
  output logic                          in_ready,
  input  logic                          cfg_valid,
  input  logic [sati_pkg::COUNT_W-1:0]  cfg_data,
  input  sati_pkg::status_t             status,
  output sati_pkg::cmd_t                cmd
);

  sati_pkg::state_t              state, state_next;
  logic [sati_pkg::COUNT_W-1:0]  entry_count;
  logic [sati_pkg::IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [sati_pkg::IDX_W-1:0]    last_idx, last_idx_next;
  logic [sati_pkg::DIV_W-1:0]    div_cnt, div_cnt_next;
  logic [sati_pkg::CNT_W-1:0]    n_use;

  always_comb begin
    if (32'(entry_count) > sati_pkg::TABLE_DEPTH) begin
      n_use = sati_pkg::CNT_W'(sati_pkg::TABLE_DEPTH);
    end else begin
      n_use = sati_pkg::CNT_W'(entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sati_pkg::S_IDLE;
      entry_count <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        entry_count <= cfg_data;
      end
    end
    scan_idx <= scan_idx_next;
    last_idx <= last_idx_next;
    div_cnt  <= div_cnt_next;
  end

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    last_idx_next = last_idx;
    div_cnt_next  = div_cnt;
    cmd           = '0;
    cmd.rd_addr   = scan_idx;
    in_ready      = (state == sati_pkg::S_IDLE);
    unique case (state)
      sati_pkg::S_IDLE: begin
        scan_idx_next = '0;
        last_idx_next = sati_pkg::IDX_W'(n_use - sati_pkg::CNT_W'(1));
        if (in_valid) begin
          if (in_func == sati_pkg::FUNC_QUERY) begin
            cmd.start  = 1'b1;
            state_next = (n_use == '0) ? sati_pkg::S_FINISH : sati_pkg::S_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      sati_pkg::S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (scan_idx == last_idx) begin
          state_next = sati_pkg::S_DRAIN;
        end else begin
          scan_idx_next = scan_idx + sati_pkg::IDX_W'(1);
        end
      end
      sati_pkg::S_DRAIN: begin
        state_next = sati_pkg::S_CHECK;
      end
      sati_pkg::S_CHECK: begin
        cmd.check = 1'b1;
        if (status.miss || status.same) begin
          state_next = sati_pkg::S_FINISH;
        end else begin
          state_next = sati_pkg::S_MUL;
        end
      end
      sati_pkg::S_MUL: begin
        cmd.mul      = 1'b1;
        div_cnt_next = '0;
        state_next   = sati_pkg::S_DIV;
      end
      sati_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == sati_pkg::DIV_W'(sati_pkg::DIV_STEPS - 1)) begin
          state_next = sati_pkg::S_FINISH;
        end else begin
          div_cnt_next = div_cnt + sati_pkg::DIV_W'(1);
        end
      end
      sati_pkg::S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = sati_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = sati_pkg::S_IDLE;
      end
    endcase
  end

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == sati_pkg::S_IDLE)
    else $error("finish did not return to idle");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> state == sati_pkg::S_DIV && div_cnt == '0)
    else $error("division did not start from step zero");

endmodule

/* rtl/sati_dp.sv */
module sati_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  sati_pkg::cmd_t                cmd,
  output sati_pkg::status_t             status,
  input  logic [3:0]                    entry_index,
  input  logic signed [15:0]            entry_wind_angle,
  input  logic signed [15:0]            entry_sail_angle,
  input  logic signed [15:0]            query_wind_angle,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            trim_angle,
  output logic                          no_bracket
);

  logic                             ram_we;
  logic [sati_pkg::ENTRY_W-1:0]     ram_rdata;
  logic                             rd_pend;
  logic [sati_pkg::IDX_W-1:0]       rd_idx;
  logic signed [15:0]               w, s;
  logic signed [15:0]               q, wl, wr, sl, sr;
  logic                             lf, rf;
  logic [sati_pkg::IDX_W-1:0]       li, ri;
  logic                             hit_l, hit_r;
  logic                             neg;
  logic [15:0]                      ds, dq, den;
  logic [31:0]                      prod;
  logic [15:0]                      rem, dvd;
  logic [16:0]                      trial;
  logic                             ge;
  logic signed [16:0]               qs, sum;

  assign ram_we = cmd.load && (32'(entry_index) < sati_pkg::TABLE_DEPTH);

  sati_ram #(
    .WIDTH (sati_pkg::ENTRY_W),
    .DEPTH (sati_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (sati_pkg::IDX_W'(entry_index)),
    .wdata ({entry_wind_angle, entry_sail_angle}),
    .raddr (cmd.rd_addr),
    .rdata (ram_rdata)
  );

  assign w     = ram_rdata[31:16];
  assign s     = ram_rdata[15:0];
  assign hit_l = (w <= q) && (!lf || (w > wl));
  assign hit_r = (w >= q) && (!rf || (w < wr));

  assign prod  = 32'(ds) * 32'(dq);
  assign trial = {rem, dvd[15]};
  assign ge    = (trial >= {1'b0, den});
  assign qs    = neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
  assign sum   = 17'(sl) + qs;

  assign status.miss     = !lf || !rf;
  assign status.same     = (li == ri);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_idx <= cmd.rd_addr;
    end
    if (cmd.start) begin
      q  <= query_wind_angle;
      lf <= 1'b0;
      rf <= 1'b0;
    end
    if (rd_pend) begin
      if (hit_l) begin
        lf <= 1'b1;
        li <= rd_idx;
        wl <= w;
        sl <= s;
      end
      if (hit_r) begin
        rf <= 1'b1;
        ri <= rd_idx;
        wr <= w;
        sr <= s;
      end
    end
    if (cmd.check) begin
      neg <= (sr < sl);
      ds  <= (sr < sl) ? 16'(sl - sr) : 16'(sr - sl);
      dq  <= 16'(q - wl);
      den <= 16'(wr - wl);
    end
    if (cmd.mul) begin
      rem <= prod[31:16];
      dvd <= prod[15:0];
    end
    if (cmd.div_step) begin
      rem <= ge ? 16'(trial - {1'b0, den}) : trial[15:0];
      dvd <= {dvd[14:0], ge};
    end
    if (cmd.finish) begin
      no_bracket <= status.miss;
      if (status.miss) begin
        trim_angle <= '0;
      end else if (status.same) begin
        trim_angle <= sl;
      end else begin
        trim_angle <= sum[15:0];
      end
    end
  end

  a_mul_bracketed: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> lf && rf && (li != ri) && (wl < q) && (q < wr))
    else $error("interpolation without a strict bracket");

  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished result not presented");

endmodule

/* rtl/sail_angle_table_interpolator_top.sv */
// sail angle table interpolator
// s_* channel: one item per handshake; s_tuser selects load (0) or query (1).
// a load writes one table entry and gives no result; a query gives one result
// item on the m_* channel: the interpolated sail angle and a miss flag.
// cfg_* channel: writes entry_count, the number of entries a query scans from
// index zero; take it only while no query is in flight.
// query steps: from acceptance to m_tvalid a query scans the first n table
// entries, n being entry_count with values above 16 counted as 16 (through the
// table ram at one entry per cycle, then one registered read), does a 16x16
// multiply, then runs a 16-step restoring divider; a query that misses or lands
// exactly on an entry skips the multiply and divide, and with n zero the query
// goes straight to its finish step.
// flow: one query at a time, the next taken only once the last has finished;
// loads are taken back to back.
// the result sits in an output register; a new item is accepted while it waits,
// and a following query holds in its last step until the receiver takes it.
// reset clears the controller state, entry_count and the output valid; table entries
// hold nothing defined until loaded.
module sail_angle_table_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_index, entry_wind_angle, entry_sail_angle,
                                 // query_wind_angle, zero pad
  input  logic [0:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // trim_angle
  output logic [0:0]  m_tuser,   // no_bracket
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data   // entry_count
);

  sati_pkg::cmd_t    cmd;
  sati_pkg::status_t status;
  logic signed [15:0] trim_angle;
  logic               no_bracket;

  assign cfg_ready = 1'b1;
  assign m_tdata   = trim_angle;
  assign m_tuser   = no_bracket;

  sati_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_func   (s_tuser[0]),
    .in_ready  (s_tready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  sati_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .entry_index      (s_tdata[3:0]),
    .entry_wind_angle (s_tdata[19:4]),
    .entry_sail_angle (s_tdata[35:20]),
    .query_wind_angle (s_tdata[51:36]),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .trim_angle       (trim_angle),
    .no_bracket       (no_bracket)
  );

endmodule

/* sim/sati_result_checker.sv */
module sati_result_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,   // entry_index, entry_wind_angle, entry_sail_angle,
                                 // query_wind_angle, zero pad
  input  logic [0:0]  s_tuser,   // func
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // trim_angle
  input  logic [0:0]  m_tuser,   // no_bracket
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [4:0]  cfg_data,  // entry_count
  output int          fail_count,
  output int          answers_due
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [sati_pkg::ANGLE_W-1:0] trim_angle;
    logic                                no_bracket;
  } sail_result_t;

  logic signed [sati_pkg::ANGLE_W-1:0] wind_tab [sati_pkg::TABLE_DEPTH];
  logic signed [sati_pkg::ANGLE_W-1:0] sail_tab [sati_pkg::TABLE_DEPTH];
  logic [sati_pkg::COUNT_W-1:0]        used_count;
  sail_result_t                        answer_q [$];
  int                                  fails = 0;

  function automatic sail_result_t interpolate(logic signed [sati_pkg::ANGLE_W-1:0] q);
    int                                  lo;
    int                                  hi;
    int                                  n;
    longint                              num;
    longint                              den;
    logic signed [sati_pkg::ANGLE_W-1:0] w;
    logic signed [sati_pkg::ANGLE_W-1:0] wl;
    logic signed [sati_pkg::ANGLE_W-1:0] wr;
    logic signed [sati_pkg::ANGLE_W-1:0] sl;
    logic signed [sati_pkg::ANGLE_W-1:0] sr;
    sail_result_t                        r;
    lo = -1;
    hi = -1;
    n  = (used_count > sati_pkg::TABLE_DEPTH) ? sati_pkg::TABLE_DEPTH : int'(used_count);
    for (int i = 0; i < n; i++) begin
      w = wind_tab[sati_pkg::IDX_W'(i)];
      if (w <= q && (lo < 0 || w > wind_tab[sati_pkg::IDX_W'(lo)])) lo = i;
      if (w >= q && (hi < 0 || w < wind_tab[sati_pkg::IDX_W'(hi)])) hi = i;
    end
    r.no_bracket = 1'b0;
    if (lo < 0 || hi < 0) begin
      r.trim_angle = '0;
      r.no_bracket = 1'b1;
    end else begin
      wl = wind_tab[sati_pkg::IDX_W'(lo)];
      wr = wind_tab[sati_pkg::IDX_W'(hi)];
      sl = sail_tab[sati_pkg::IDX_W'(lo)];
      sr = sail_tab[sati_pkg::IDX_W'(hi)];
      if (lo == hi) begin
        r.trim_angle = sl;
      end else begin
        den = longint'(wr) - longint'(wl);
        num = (longint'(sr) - longint'(sl)) * (longint'(q) - longint'(wl));
        if (den == 0) r.trim_angle = sl;
        else r.trim_angle = sati_pkg::ANGLE_W'(longint'(sl) + num / den);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sail_result_t want;
    if (rst) begin
      used_count = '0;
      answer_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) used_count = cfg_data;
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == sati_pkg::FUNC_LOAD) begin
          wind_tab[s_tdata[3:0]] = s_tdata[19:4];
          sail_tab[s_tdata[3:0]] = s_tdata[35:20];
        end else begin
          answer_q.push_back(interpolate(s_tdata[51:36]));
        end
      end
      if (m_tvalid && m_tready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result item with no query waiting, expected none, got %0d/%0b",
                   $time, $signed(m_tdata), m_tuser[0]);
          fails++;
        end else begin
          want = answer_q.pop_front();
          if (m_tdata !== want.trim_angle) begin
            $display("%0t: trim_angle expected %0d got %0d",
                     $time, want.trim_angle, $signed(m_tdata));
            fails++;
          end
          if (m_tuser[0] !== want.no_bracket) begin
            $display("%0t: no_bracket expected %0b got %0b",
                     $time, want.no_bracket, m_tuser[0]);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    answers_due <= answer_q.size();
  end

endmodule

/* sim/sail_angle_table_interpolator_top_test.sv */
module sail_angle_table_interpolator_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {SPREAD_FULL, SPREAD_CLUSTER, SPREAD_EXTREME} spread_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  int          fail_count;
  int          answers_due;

  bit          calm = 1'b0;
  int          items_sent = 0;
  logic [15:0] shadow_wind [sati_pkg::TABLE_DEPTH];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sail_angle_table_interpolator_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  sati_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .answers_due (answers_due)
  );

  always @(posedge clk) m_tready <= calm || ($urandom_range(99) >= 28);

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic send_item(logic func, logic [3:0] idx, logic [15:0] wa,
                           logic [15:0] sa, logic [15:0] qa);
    int gaps;
    gaps = 0;
    if (!calm) begin
      while ($urandom_range(99) < 28) gaps++;
      if ($urandom_range(99) < 4) gaps += $urandom_range(60);
    end
    if (gaps > 0) begin
      s_tvalid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {4'b0000, qa, sa, wa, idx};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (func == sati_pkg::FUNC_LOAD) shadow_wind[idx] = wa;
  endtask

  task automatic load_entry(logic [3:0] idx, logic [15:0] wa, logic [15:0] sa);
    send_item(sati_pkg::FUNC_LOAD, idx, wa, sa, 16'($urandom));
  endtask

  task automatic ask(logic [15:0] qa);
    send_item(sati_pkg::FUNC_QUERY, 4'($urandom), 16'($urandom), 16'($urandom), qa);
  endtask

  // entry_count changes only with nothing in flight
  task automatic set_count(logic [4:0] n);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] pick_angle(spread_t spread);
    case (spread)
      SPREAD_CLUSTER: return 16'((int'($urandom_range(8)) - 4) * 64);
      SPREAD_EXTREME: begin
        case ($urandom_range(4))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h8001;
          3: return 16'h7ffe;
          default: return 16'($urandom);
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_query(spread_t spread);
    int r;
    r = $urandom_range(9);
    if (r < 3)
      return shadow_wind[sati_pkg::IDX_W'($urandom_range(sati_pkg::TABLE_DEPTH - 1))];
    if (r == 3)
      return shadow_wind[sati_pkg::IDX_W'($urandom_range(sati_pkg::TABLE_DEPTH - 1))] +
             ($urandom_range(1) ? 16'h0001 : 16'hffff);
    if (r == 4) return pick_angle(SPREAD_EXTREME);
    return pick_angle(spread);
  endfunction

  initial begin : stimulus
    int      dir_wind [sati_pkg::TABLE_DEPTH];
    int      dir_sail [sati_pkg::TABLE_DEPTH];
    spread_t spread;
    int      r;
    int      n;
    int      len;
    logic [3:0] idx;
    // entries 3 and 5 share a wind angle; 6 and 7 give the steepest rising slope
    dir_wind = '{6400, -32768, 32767, 0, -6400, 0, 12800, 19200,
                 -12800, 25600, -19200, 3200, -25600, 9600, 28800, -3200};
    dir_sail = '{1000, -32768, 32767, 500, -2000, 900, -32768, 32767,
                 2000, 0, -100, -3000, 4000, 20000, 100, 7000};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty table: every query misses
    ask(16'h8000);
    ask(16'h7fff);
    for (int i = 0; i < sati_pkg::TABLE_DEPTH; i++)
      load_entry(4'(i), 16'(dir_wind[sati_pkg::IDX_W'(i)]),
                 16'(dir_sail[sati_pkg::IDX_W'(i)]));
    set_count(5'd16);
    ask(16'h8000);
    ask(16'h7fff);
    ask(16'h0000);
    ask(16'd16000);
    ask(16'hffff);
    set_count(5'd1);
    ask(16'h8000);

    while (items_sent < 800) begin
      spread = spread_t'($urandom_range(2));
      r = $urandom_range(9);
      if (r < 2) n = $urandom_range(2);
      else if (r < 6) n = $urandom_range(3, 16);
      else if (r < 8) n = 16;
      else n = $urandom_range(17, 31);
      calm = (items_sent >= 350 && items_sent < 500);
      set_count(5'(n));
      len = $urandom_range(15, 45);
      repeat (len) begin
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(1) && n > 0 && n < sati_pkg::TABLE_DEPTH)
            idx = 4'($urandom_range(n - 1));
          else
            idx = 4'($urandom_range(sati_pkg::TABLE_DEPTH - 1));
          load_entry(idx, pick_angle(spread), pick_angle(spread));
        end else begin
          ask(pick_query(spread));
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (answers_due != 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && answers_due == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sail_angle_table_interpolator_top.f */
rtl/sati_pkg.sv
rtl/sati_ram.sv
rtl/sati_ctrl.sv
rtl/sati_dp.sv
rtl/sail_angle_table_interpolator_top.sv
sim/sati_result_checker.sv
sim/sail_angle_table_interpolator_top_test.sv
